// ----- sv/fpmt_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// fpmt_pkg
// Shared types and constants of the prefix-maximum Fenwick tree unit.
// ----------------------------------------------------------------------------
package fpmt_pkg;

	localparam int DATA_W          = 32;
	localparam int POS_W           = 11;
	localparam int SIZE_W          = 11;
	localparam int MAX_ENTRIES_DEF = 1024;

	localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(1024);
	localparam logic [DATA_W-1:0] SIGN_BIAS  = {1'b1, {(DATA_W-1){1'b0}}};
	localparam logic [DATA_W-1:0] BIASED_MIN = '0;

	localparam logic OP_UPDATE = 1'b0;
	localparam logic OP_QUERY  = 1'b1;

	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_WALK,
		ST_RESULT
	} state_t;

	// result handed from the walk sequencer to the output register, biased form
	typedef struct packed {
		logic              valid;
		logic [DATA_W-1:0] data;
	} res_t;

endpackage
`default_nettype wire

// ----- sv/fenwick_prefix_max_tree_unit.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// fenwick_prefix_max_tree_unit
// Prefix-maximum Fenwick tree: update items raise entries, query items return
// the maximum over a prefix.
// ----------------------------------------------------------------------------
// After reset the unit sweeps its store to the lowest signed value, one entry
// per cycle, and holds in_stall high meanwhile (config writes are taken). An
// accepted item then walks its tree nodes in turn in the single-port-read
// store, at most ceil(log2 n)+1 nodes. A query holds its result until the
// output register takes it. Updates that fall outside the size in use, or
// that have a negative position, end at acceptance without a walk. One item
// is in work at a time; the output register lets the next item start while a
// result waits.
// ----------------------------------------------------------------------------
module fenwick_prefix_max_tree_unit #(
	parameter int MAX_ENTRIES = fpmt_pkg::MAX_ENTRIES_DEF
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               in_valid,
	output logic                                    in_stall,
	input  wire logic                               op,
	input  wire logic signed [fpmt_pkg::POS_W-1:0]  position,
	input  wire logic signed [fpmt_pkg::DATA_W-1:0] value,
	output logic                                    out_valid,
	input  wire logic                               out_stall,
	output logic signed      [fpmt_pkg::DATA_W-1:0] prefix_max,
	input  wire logic                               cfg_valid,
	output logic                                    cfg_ready,
	input  wire logic        [fpmt_pkg::SIZE_W-1:0] cfg_data
);
	import fpmt_pkg::*;

	logic [SIZE_W-1:0] size_q;
	logic              out_valid_q;
	logic [DATA_W-1:0] out_data_q;
	res_t              res;
	logic              res_take;

	fpmt_core #(
		.MAX_ENTRIES(MAX_ENTRIES)
	) u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.op      (op),
		.position(position),
		.value   (value),
		.size    (size_q),
		.res     (res),
		.res_take(res_take)
	);

	assign cfg_ready  = 1'b1;
	assign res_take   = res.valid && (!out_valid_q || !out_stall);
	assign out_valid  = out_valid_q;
	assign prefix_max = out_data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_q      <= SIZE_RESET;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) size_q <= cfg_data;
			if (res_take) out_valid_q <= 1'b1;
			else if (!out_stall) out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_take) out_data_q <= res.data ^ SIGN_BIAS;
	end

endmodule
`default_nettype wire

// ----- sv/fpmt_ram.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// fpmt_ram
// Generic simple dual-port RAM, one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module fpmt_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
	input  wire logic [WIDTH-1:0]         wr_data,
	input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic      [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_data <= mem_q[rd_addr];
	end

endmodule
`default_nettype wire

// ----- sv/fpmt_core.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// fpmt_core
// Walk sequencer: clears the store after reset, then walks the update or query
// chain one node per cycle through a single shared compare unit.
// ----------------------------------------------------------------------------
module fpmt_core #(
	parameter int MAX_ENTRIES = fpmt_pkg::MAX_ENTRIES_DEF
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              in_valid,
	output logic                                   in_stall,
	input  wire logic                              op,
	input  wire logic signed [fpmt_pkg::POS_W-1:0] position,
	input  wire logic        [fpmt_pkg::DATA_W-1:0] value,
	input  wire logic        [fpmt_pkg::SIZE_W-1:0] size,
	output fpmt_pkg::res_t                         res,
	input  wire logic                              res_take
);
	import fpmt_pkg::*;

	localparam int AW = $clog2(MAX_ENTRIES);
	localparam int WW = (AW + 1 > SIZE_W) ? AW + 1 : SIZE_W;
	localparam logic [AW-1:0] LAST_ADDR = AW'(MAX_ENTRIES - 1);
	localparam logic [WW-1:0] MAX_W     = WW'(MAX_ENTRIES);

	state_t            state_q, state_d;
	logic              op_q;
	logic [DATA_W-1:0] val_q;
	logic [DATA_W-1:0] best_q;
	logic [WW-1:0]     idx_q;
	logic [WW-1:0]     n_q;
	logic [AW-1:0]     clr_q;

	logic              accept;
	logic              negative;
	logic [WW-1:0]     pos_w;
	logic [WW-1:0]     size_w;
	logic [WW-1:0]     n_w;
	logic [WW-1:0]     start_idx;
	logic [WW-1:0]     up_next;
	logic [WW-1:0]     low;
	logic [WW-1:0]     next_idx;
	logic [DATA_W-1:0] cmp_b;
	logic              gt;

	logic              we;
	logic [AW-1:0]     wr_addr;
	logic [DATA_W-1:0] wr_data;
	logic [AW-1:0]     rd_addr;
	logic [DATA_W-1:0] rd_data;

	assign accept   = in_valid && (state_q == ST_IDLE);
	assign negative = position[POS_W-1];
	assign pos_w    = WW'(position[POS_W-2:0]);
	assign size_w   = WW'(size);
	assign n_w      = (size_w > MAX_W) ? MAX_W : size_w;

	assign start_idx = (op == OP_QUERY && pos_w >= n_w) ? n_w - WW'(1) : pos_w;
	assign up_next   = idx_q | (idx_q + WW'(1));
	assign low       = idx_q & (idx_q + WW'(1));
	assign next_idx  = (op_q == OP_UPDATE) ? up_next : low - WW'(1);

	// shared compare unit
	assign cmp_b = (op_q == OP_UPDATE) ? val_q : best_q;
	assign gt    = rd_data > cmp_b;

	fpmt_ram #(
		.WIDTH(DATA_W),
		.DEPTH(MAX_ENTRIES)
	) u_ram (
		.clk    (clk),
		.we     (we),
		.wr_addr(wr_addr),
		.wr_data(wr_data),
		.rd_addr(rd_addr),
		.rd_data(rd_data)
	);

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_CLEAR: begin
				if (clr_q == LAST_ADDR) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (accept) begin
					if (op == OP_UPDATE) begin
						if (!negative && pos_w < n_w) state_d = ST_WALK;
					end else begin
						if (negative || n_w == '0) state_d = ST_RESULT;
						else state_d = ST_WALK;
					end
				end
			end
			ST_WALK: begin
				if (op_q == OP_UPDATE) begin
					if (up_next >= n_q) state_d = ST_IDLE;
				end else begin
					if (low == '0) state_d = ST_RESULT;
				end
			end
			ST_RESULT: begin
				if (res_take) state_d = ST_IDLE;
			end
			default: state_d = ST_CLEAR;
		endcase
	end

	always_comb begin
		in_stall  = (state_q != ST_IDLE);
		res.valid = (state_q == ST_RESULT);
		res.data  = best_q;
		we        = 1'b0;
		wr_addr   = idx_q[AW-1:0];
		wr_data   = val_q;
		rd_addr   = next_idx[AW-1:0];
		case (state_q)
			ST_CLEAR: begin
				we      = 1'b1;
				wr_addr = clr_q;
				wr_data = BIASED_MIN;
			end
			ST_IDLE: begin
				rd_addr = start_idx[AW-1:0];
			end
			ST_WALK: begin
				// stored entry not above the new value: raise it
				we = (op_q == OP_UPDATE) && !gt;
			end
			ST_RESULT: begin
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			clr_q   <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_CLEAR) clr_q <= clr_q + AW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_q   <= op;
			val_q  <= value ^ SIGN_BIAS;
			best_q <= BIASED_MIN;
			idx_q  <= start_idx;
			n_q    <= n_w;
		end else if (state_q == ST_WALK) begin
			idx_q <= next_idx;
			if (op_q == OP_QUERY && gt) best_q <= rd_data;
		end
	end

endmodule
`default_nettype wire
